// ----- rtl/snt_pkg.sv -----
// Shared types and constants for the sigmoid neuron training unit.
// Used by snt_ctrl, snt_datapath and sigmoid_neuron_train_unit; no dependencies.
`default_nettype none

package snt_pkg;

    // Operation codes carried on the input channel
    typedef enum logic [2:0] {
        OP_WRITE  = 3'd0,
        OP_INPUT  = 3'd1,
        OP_TARGET = 3'd2,
        OP_APPLY  = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    // Source of the shared memory read address
    typedef enum logic [1:0] {
        RD_POS,
        RD_BIAS,
        RD_WIDX,
        RD_WALK
    } rd_src_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_IN_MAC,
        S_BIAS_RD,
        S_BIAS_SUM,
        S_LOOKUP,
        S_EMIT_ACT,
        S_EMIT_RD,
        S_T_DERIV,
        S_T_GRAD,
        S_WALK,
        S_DRAIN
    } state_t;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic    load_item;
        logic    wr_weight;
        logic    rd_en;
        rd_src_t rd_src;
        logic    mac;
        logic    bias_sum;
        logic    lookup;
        logic    emit_act;
        logic    emit_rd;
        logic    t_deriv;
        logic    t_grad;
        logic    walk;
    } cmd_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        op_t  op;
        logic last;
        logic pos_full;
        logic out_busy;
        logic pipe_busy;
    } status_t;

    localparam logic [15:0] LEARN_RATE_RESET = 16'd655;
    localparam logic [12:0] ONE_Q12          = 13'd4096;

endpackage

`default_nettype wire

// ----- rtl/snt_ctrl.sv -----
// Sequencer for the sigmoid neuron training unit.
// Drives snt_datapath through cmd_t and reads its status_t; depends on snt_pkg.
`default_nettype none

module snt_ctrl #(
    parameter int NUM_INPUTS = 8,
    localparam int AW = $clog2(NUM_INPUTS + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire snt_pkg::status_t status,
    output snt_pkg::cmd_t         cmd,
    output logic [AW-1:0]         walk_idx
);
    import snt_pkg::*;

    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_INPUTS);

    state_t         state_reg, state_next;
    logic [AW-1:0]  walk_reg, walk_next;

    // State and walk counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            walk_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
        end
    end

    assign walk_idx = walk_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        walk_next  = walk_reg;
        in_stall   = 1'b1;
        cmd        = '0;
        cmd.rd_src = RD_WALK;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (status.op)
                    OP_WRITE:
                    begin
                        cmd.wr_weight = 1'b1;
                        state_next    = S_IDLE;
                    end
                    OP_INPUT:
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_src = RD_POS;
                        if (!status.pos_full)
                            state_next = S_IN_MAC;
                        else if (status.last)
                            state_next = S_BIAS_RD;
                        else
                            state_next = S_IDLE;
                    end
                    OP_TARGET: state_next = S_T_DERIV;
                    OP_APPLY:  state_next = S_WALK;
                    OP_READ:
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_src = RD_WIDX;
                        state_next = S_EMIT_RD;
                    end
                    default:   state_next = S_IDLE;
                endcase
            end
            S_IN_MAC:
            begin
                cmd.mac    = 1'b1;
                state_next = status.last ? S_BIAS_RD : S_IDLE;
            end
            S_BIAS_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_BIAS;
                state_next = S_BIAS_SUM;
            end
            S_BIAS_SUM:
            begin
                cmd.bias_sum = 1'b1;
                state_next   = S_LOOKUP;
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = S_EMIT_ACT;
            end
            S_EMIT_ACT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit_act = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_EMIT_RD:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit_rd = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_T_DERIV:
            begin
                cmd.t_deriv = 1'b1;
                state_next  = S_T_GRAD;
            end
            S_T_GRAD:
            begin
                cmd.t_grad = 1'b1;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                // issue one weight/accumulator read per cycle
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_WALK;
                cmd.walk   = 1'b1;
                if (walk_reg == LAST_IDX)
                begin
                    walk_next  = '0;
                    state_next = S_DRAIN;
                end
                else
                    walk_next = walk_reg + 1'b1;
            end
            S_DRAIN:
            begin
                if (!status.pipe_busy)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/snt_datapath.sv -----
// Datapath of the sigmoid neuron training unit: weight, input and gradient
// memories, MAC, sigmoid table, gradient and update pipelines. Depends on snt_pkg.
`default_nettype none

module snt_datapath #(
    parameter int NUM_INPUTS = 8,
    parameter int SIGMOID_TABLE_DEPTH = 256,
    localparam int AW = $clog2(NUM_INPUTS + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire snt_pkg::cmd_t      cmd,
    input  wire logic [AW-1:0]      walk_idx,
    output snt_pkg::status_t        status,
    input  wire logic [2:0]         operation,
    input  wire logic [3:0]         weight_index,
    input  wire logic signed [15:0] value,
    input  wire logic               last_input,
    input  wire logic               cfg_write,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               out_stall,
    output logic                    out_valid,
    output logic signed [15:0]      result_value,
    output logic                    result_kind
);
    import snt_pkg::*;

    localparam int XW  = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam int IXW = (AW > 4) ? AW : 4;
    localparam int TW  = $clog2(SIGMOID_TABLE_DEPTH);
    localparam logic [AW-1:0] BIAS_IDX = AW'(NUM_INPUTS);

    typedef logic [12:0] sig_tab_t [SIGMOID_TABLE_DEPTH];

    // Restoring unsigned divide, used only while building the table
    function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], a[i]};
            if (r >= b)
            begin
                r    = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Sigmoid at each bin center, built at elaboration
    function automatic sig_tab_t build_sig_tab();
        sig_tab_t        tab;
        longint unsigned off;
        longint unsigned y;
        longint unsigned z;
        longint unsigned term;
        longint unsigned u;
        longint          c;
        longint          s;
        longint          num;
        longint          den;
        for (int k = 0; k < SIGMOID_TABLE_DEPTH; k++)
        begin
            off  = udiv64($unsigned(longint'(2 * k + 1) << 33),
                          $unsigned(longint'(SIGMOID_TABLE_DEPTH)));
            c    = longint'(off) - (longint'(1) << 33);
            y    = (c < 0) ? longint'(-c) : longint'(c);
            z    = y >> 4;
            term = longint'(1) << 30;
            s    = longint'(1) << 30;
            for (int n = 1; n <= 12; n++)
            begin
                term = udiv64((term * z) >> 30, $unsigned(longint'(n)));
                if ((n & 1) != 0)
                    s = s - longint'(term);
                else
                    s = s + longint'(term);
            end
            for (int n = 0; n < 4; n++)
            begin
                u = s;
                s = longint'((u * u + (longint'(1) << 29)) >> 30);
            end
            num    = (c >= 0) ? (longint'(1) << 30) : s;
            den    = (longint'(1) << 30) + s;
            tab[k] = 13'(udiv64($unsigned(num * 4096 + (den >>> 1)), $unsigned(den)));
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TAB = build_sig_tab();

    // Item and control registers
    op_t                   op_reg;
    logic [3:0]            widx_reg;
    logic signed [15:0]    val_reg;
    logic                  last_reg;
    logic [15:0]           lr_reg;
    logic [AW-1:0]         pos_reg;
    logic [AW-1:0]         ex_cnt_reg;
    logic signed [39:0]    sum_reg;
    logic [12:0]           act_reg;
    logic signed [15:0]    xs_reg;
    logic [10:0]           d_reg;
    logic signed [15:0]    g_reg;

    // Memories and read registers
    logic [15:0]           w_mem [NUM_INPUTS+1];
    logic [47:0]           g_mem [NUM_INPUTS+1];
    logic [15:0]           x_mem [NUM_INPUTS];
    logic [NUM_INPUTS:0]   w_vld_reg;
    logic [NUM_INPUTS:0]   g_vld_reg;
    logic signed [15:0]    w_rd_reg;
    logic signed [47:0]    g_rd_reg;
    logic signed [15:0]    x_rd_reg;
    logic                  w_ok_reg, g_ok_reg, x_ok_reg;

    // Walk pipeline
    logic                  s1_vld_reg, s2_vld_reg;
    logic [AW-1:0]         s1_idx_reg, s2_idx_reg;
    logic [39:0]           plo_reg;
    logic signed [40:0]    phi_reg;
    logic signed [15:0]    w1_reg;

    // Output register
    logic                  out_valid_reg;
    logic signed [15:0]    res_reg;
    logic                  kind_reg;

    // Combinational signals
    logic [IXW-1:0]        widx_ext;
    logic                  widx_ok;
    logic [AW-1:0]         widx_addr;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         thresh;
    logic                  w_in, x_in;
    logic signed [15:0]    w_val;
    logic signed [47:0]    acc_cur;
    logic signed [31:0]    mac_prod;
    logic signed [39:0]    bias_sum;
    logic signed [39:0]    bias_fl;
    logic [15:0]           lut_u;
    logic [31:0]           lut_prod;
    logic [TW-1:0]         lut_idx;
    logic [25:0]           d_full;
    logic signed [17:0]    t_diff;
    logic signed [29:0]    g_prod;
    logic signed [16:0]    x_eff;
    logic signed [32:0]    gx;
    logic signed [48:0]    acc_sum;
    logic signed [47:0]    acc_sat;
    logic signed [64:0]    upd_p;
    logic signed [36:0]    upd_dw;
    logic signed [37:0]    upd_w;
    logic signed [15:0]    upd_sat;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [15:0]           w_wdata;
    logic                  g_we;
    logic                  g_clr;

    // Decode address sources
    assign widx_ext  = IXW'(widx_reg);
    assign widx_ok   = widx_ext <= IXW'(NUM_INPUTS);
    assign widx_addr = widx_ok ? widx_ext[AW-1:0] : '0;
    assign thresh    = (ex_cnt_reg > pos_reg) ? ex_cnt_reg : pos_reg;

    always_comb
    begin
        unique case (cmd.rd_src)
            RD_POS:  rd_addr = pos_reg;
            RD_BIAS: rd_addr = BIAS_IDX;
            RD_WIDX: rd_addr = widx_addr;
            RD_WALK: rd_addr = walk_idx;
            default: rd_addr = walk_idx;
        endcase
    end

    assign w_in = rd_addr <= BIAS_IDX;
    assign x_in = rd_addr < BIAS_IDX;

    // Capture the accepted beat and the learning rate
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg   <= op_t'(operation);
            widx_reg <= weight_index;
            val_reg  <= value;
            last_reg <= last_input;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lr_reg <= LEARN_RATE_RESET;
        else if (cfg_write)
            lr_reg <= cfg_data;
    end

    // Memory reads, data registered
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            if (w_in)
            begin
                w_rd_reg <= w_mem[rd_addr];
                g_rd_reg <= g_mem[rd_addr];
            end
            if (x_in)
                x_rd_reg <= x_mem[rd_addr[XW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_ok_reg <= 1'b0;
            g_ok_reg <= 1'b0;
            x_ok_reg <= 1'b0;
        end
        else if (cmd.rd_en)
        begin
            w_ok_reg <= w_in && w_vld_reg[rd_addr];
            g_ok_reg <= w_in && g_vld_reg[rd_addr];
            x_ok_reg <= x_in && (rd_addr < thresh);
        end
    end

    assign w_val   = w_ok_reg ? w_rd_reg : 16'sd0;
    assign acc_cur = g_ok_reg ? g_rd_reg : 48'sd0;

    // Memory writes
    assign w_we    = (cmd.wr_weight && widx_ok) || s2_vld_reg;
    assign w_waddr = s2_vld_reg ? s2_idx_reg : widx_addr;
    assign w_wdata = s2_vld_reg ? upd_sat : val_reg;
    assign g_we    = s1_vld_reg && (op_reg == OP_TARGET);
    assign g_clr   = s2_vld_reg;

    always_ff @(posedge clk)
    begin
        if (w_we)
            w_mem[w_waddr] <= w_wdata;
        if (g_we)
            g_mem[s1_idx_reg] <= acc_sat;
        if (cmd.mac)
            x_mem[pos_reg[XW-1:0]] <= val_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_vld_reg <= '0;
            g_vld_reg <= '0;
        end
        else
        begin
            if (w_we)
                w_vld_reg[w_waddr] <= 1'b1;
            if (g_we)
                g_vld_reg[s1_idx_reg] <= 1'b1;
            if (g_clr)
                g_vld_reg[s2_idx_reg] <= 1'b0;
        end
    end

    // Forward pass: MAC, bias, saturate, table lookup
    assign mac_prod = val_reg * w_val;
    assign bias_sum = sum_reg + (40'(w_val) <<< 12);
    assign bias_fl  = bias_sum >>> 12;
    assign lut_u    = {~xs_reg[15], xs_reg[14:0]};
    assign lut_prod = 32'(lut_u) * 32'(SIGMOID_TABLE_DEPTH);
    assign lut_idx  = lut_prod[16 +: TW];

    always_ff @(posedge clk)
    begin
        if (cmd.bias_sum)
        begin
            if (bias_fl > 40'sd32767)
                xs_reg <= 16'sh7fff;
            else if (bias_fl < -40'sd32768)
                xs_reg <= -16'sh8000;
            else
                xs_reg <= bias_fl[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            ex_cnt_reg <= '0;
            sum_reg    <= '0;
            act_reg    <= '0;
        end
        else if (cmd.mac)
        begin
            sum_reg <= sum_reg + 40'(mac_prod);
            pos_reg <= pos_reg + 1'b1;
        end
        else if (cmd.lookup)
        begin
            act_reg    <= SIG_TAB[lut_idx];
            ex_cnt_reg <= pos_reg;
            pos_reg    <= '0;
            sum_reg    <= '0;
        end
    end

    // Target: derivative, then error gradient
    assign d_full = 26'(act_reg) * 26'(ONE_Q12 - act_reg);
    assign t_diff = 18'(val_reg) - $signed(18'(act_reg));
    assign g_prod = $signed({1'b0, d_reg}) * t_diff;

    always_ff @(posedge clk)
    begin
        if (cmd.t_deriv)
            d_reg <= d_full[22:12];
        if (cmd.t_grad)
            g_reg <= 16'(g_prod >>> 12);
    end

    // Walk stage 1: gradient accumulate or partial products of the update
    assign x_eff   = (s1_idx_reg == BIAS_IDX) ? 17'sd4096
                                                : (x_ok_reg ? 17'(x_rd_reg) : 17'sd0);
    assign gx      = g_reg * x_eff;
    assign acc_sum = 49'(acc_cur) + 49'(gx);

    always_comb
    begin
        if (acc_sum[48] != acc_sum[47])
            acc_sat = acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        else
            acc_sat = acc_sum[47:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= cmd.walk;
            s2_vld_reg <= s1_vld_reg && (op_reg == OP_APPLY);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk)
            s1_idx_reg <= rd_addr;
        if (s1_vld_reg)
        begin
            plo_reg    <= 40'(lr_reg) * 40'(acc_cur[23:0]);
            phi_reg    <= $signed({1'b0, lr_reg}) * $signed(acc_cur[47:24]);
            w1_reg     <= w_val;
            s2_idx_reg <= s1_idx_reg;
        end
    end

    // Walk stage 2: combine, round, add to weight, saturate
    assign upd_p  = (65'(phi_reg) <<< 24) + $signed(65'(plo_reg)) + 65'sd134217728;
    assign upd_dw = upd_p[64:28];
    assign upd_w  = 38'(w1_reg) + 38'(upd_dw);

    always_comb
    begin
        if (upd_w > 38'sd32767)
            upd_sat = 16'sh7fff;
        else if (upd_w < -38'sd32768)
            upd_sat = -16'sh8000;
        else
            upd_sat = upd_w[15:0];
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_act || cmd.emit_rd)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_act)
        begin
            res_reg  <= 16'(act_reg);
            kind_reg <= 1'b0;
        end
        else if (cmd.emit_rd)
        begin
            res_reg  <= widx_ok ? w_val : 16'sd0;
            kind_reg <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = res_reg;
    assign result_kind  = kind_reg;

    // Status back to the sequencer
    assign status.op        = op_reg;
    assign status.last      = last_reg;
    assign status.pos_full  = pos_reg >= BIAS_IDX;
    assign status.out_busy  = out_valid_reg && out_stall;
    assign status.pipe_busy = s1_vld_reg || s2_vld_reg;

endmodule

`default_nettype wire

// ----- rtl/sigmoid_neuron_train_unit.sv -----
// Sigmoid neuron training unit, top level: sequencer plus datapath.
// Depends on snt_pkg, snt_ctrl and snt_datapath.
//
// Input channel (in_valid/in_stall) carries one operation per beat:
// write weight, input element, target, apply batch update, read weight.
// Output channel (out_valid/out_stall) returns an activation after the
// last input element of an example, or a weight on a read.
// Beats are handled one at a time by the sequencer through the single
// memory read port, and a new beat is taken only once it is back in idle;
// an input element that finds the example full skips the MAC.
// The walks of target and apply touch one weight per cycle through a
// one-stage (target) or two-stage (apply) pipeline behind the memory read.
// Results sit in an output register; the next beat is taken while a result
// waits. A stalled receiver holds a finished result only when a new one is
// ready to load, and then the block waits in place.
// Reset clears weights, gradient accumulators, example position and the
// last activation at once and loads learn_rate with 655 (about 0.01).
// cfg_write loads learn_rate; write it only while the block is idle.
`default_nettype none

module sigmoid_neuron_train_unit #(
    parameter int NUM_INPUTS = 8,
    parameter int SIGMOID_TABLE_DEPTH = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         operation,
    input  wire logic [3:0]         weight_index,
    input  wire logic signed [15:0] value,
    input  wire logic               last_input,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      result_value,
    output logic                    result_kind
);
    import snt_pkg::*;

    localparam int AW = $clog2(NUM_INPUTS + 1);

    cmd_t          cmd;
    status_t       status;
    logic [AW-1:0] walk_idx;

    // Sequencer
    snt_ctrl #(
        .NUM_INPUTS(NUM_INPUTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd),
        .walk_idx (walk_idx)
    );

    // Datapath
    snt_datapath #(
        .NUM_INPUTS          (NUM_INPUTS),
        .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .walk_idx     (walk_idx),
        .status       (status),
        .operation    (operation),
        .weight_index (weight_index),
        .value        (value),
        .last_input   (last_input),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .result_value (result_value),
        .result_kind  (result_kind)
    );

endmodule

`default_nettype wire
